FILE: hw/rtl/gpt_pkg.sv
// ----------------------------------------------------------------------------
// General purpose timer package
// Shared constants, codes, types and the byte-lane merge helper for the
// three channel match timer.
// ----------------------------------------------------------------------------
package gpt_pkg;

  // Number of timers that exist (1 to 3) and the counter width (8 to 32).
  localparam int TIMER_COUNT = 3;
  localparam int COUNT_WIDTH = 32;

  // The register map always reserves room for three timers.
  localparam int MAX_TIMERS  = 3;
  localparam int STATUS_W    = 3 * MAX_TIMERS;
  localparam int CTRL_W      = 12;

  localparam logic [31:0] REVISION_WORD = 32'h0001_0801;

  // Word addresses above the timer banks.
  localparam logic [3:0] REG_CONTROL  = 4'hC;
  localparam logic [3:0] REG_STATUS   = 4'hD;
  localparam logic [3:0] REG_MASK     = 4'hE;
  localparam logic [3:0] REG_REVISION = 4'hF;

  // Register inside one timer bank.
  localparam logic [1:0] SUB_COUNT  = 2'd0;
  localparam logic [1:0] SUB_RELOAD = 2'd1;
  localparam logic [1:0] SUB_MATCH0 = 2'd2;
  localparam logic [1:0] SUB_MATCH1 = 2'd3;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_t;

  // Control bundle from the top level to one timer channel.
  typedef struct packed {
    logic       tick;
    logic       up;
    logic       wr;
    logic [1:0] sub;
    logic [1:0] lane;
    logic [7:0] wr_byte;
  } chan_ctl_t;

  // Replaces one byte lane of a 32-bit word.
  function automatic logic [31:0] merge_byte(input logic [31:0] old_word,
                                             input logic [1:0]  lane,
                                             input logic [7:0]  data);
    logic [31:0] lane_mask;
    lane_mask = 32'h0000_00FF << {lane, 3'b000};
    return (old_word & ~lane_mask) | (32'(data) << {lane, 3'b000});
  endfunction

endpackage

FILE: hw/rtl/gpt_channel.sv
// ----------------------------------------------------------------------------
// Timer channel
// One counter with its reload and two match registers, byte-wide write
// access and the compare, reload and step logic of one tick.
// ----------------------------------------------------------------------------
module gpt_channel import gpt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  chan_ctl_t   ctl_i,
  output logic [2:0]  ev_o,
  output logic [31:0] rd_word_o
);

  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [COUNT_WIDTH-1:0] reload_r, reload_nxt;
  logic [COUNT_WIDTH-1:0] match0_r, match0_nxt;
  logic [COUNT_WIDTH-1:0] match1_r, match1_nxt;
  logic [COUNT_WIDTH-1:0] term_val;
  logic [COUNT_WIDTH-1:0] old_val;
  logic [31:0]            merged;
  logic                   at_term;

  assign term_val = ctl_i.up ? {COUNT_WIDTH{1'b1}} : {COUNT_WIDTH{1'b0}};
  assign at_term  = (count_r == term_val);

  // Events are reported as seen before the counter moves.
  assign ev_o = ctl_i.tick ? {at_term, count_r == match1_r, count_r == match0_r} : 3'b000;

  always_comb begin
    case (ctl_i.sub)
      SUB_COUNT:  old_val = count_r;
      SUB_RELOAD: old_val = reload_r;
      SUB_MATCH0: old_val = match0_r;
      SUB_MATCH1: old_val = match1_r;
      default:    old_val = count_r;
    endcase
  end

  assign merged    = merge_byte(32'(old_val), ctl_i.lane, ctl_i.wr_byte);
  assign rd_word_o = 32'(old_val);

  always_comb begin
    count_nxt  = count_r;
    reload_nxt = reload_r;
    match0_nxt = match0_r;
    match1_nxt = match1_r;
    if (ctl_i.tick) begin
      if (at_term) begin
        count_nxt = reload_r;
      end else if (ctl_i.up) begin
        count_nxt = count_r + 1'b1;
      end else begin
        count_nxt = count_r - 1'b1;
      end
    end
    if (ctl_i.wr) begin
      case (ctl_i.sub)
        SUB_COUNT:  count_nxt  = merged[COUNT_WIDTH-1:0];
        SUB_RELOAD: reload_nxt = merged[COUNT_WIDTH-1:0];
        SUB_MATCH0: match0_nxt = merged[COUNT_WIDTH-1:0];
        SUB_MATCH1: match1_nxt = merged[COUNT_WIDTH-1:0];
        default:    count_nxt  = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      reload_r <= '0;
      match0_r <= '0;
      match1_r <= '0;
    end else begin
      count_r  <= count_nxt;
      reload_r <= reload_nxt;
      match0_r <= match0_nxt;
      match1_r <= match1_nxt;
    end
  end

endmodule

FILE: hw/rtl/general_purpose_timer_block_unit.sv
// ----------------------------------------------------------------------------
// General purpose timer block
// Three match timers behind a byte-wide register bus; every item is a clock
// tick, a bus read or a bus write, and each gives one result word.
// ----------------------------------------------------------------------------
// A result word is loaded into the output register when its item is
// accepted. The block takes one item per cycle unless the output stalls;
// the input is taken whenever the output register is empty or being
// drained in the same cycle.
// Reset (rst_n low, synchronous) clears all counters, registers, status,
// the delayed status and interrupt pipelines and the output valid flag.
module general_purpose_timer_block_unit import gpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [5:0] in_address,
  input  logic [7:0] in_write_data,
  input  logic       in_slow_tick,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic [2:0] out_timer_irq
);

  // Bus and tick decode of the word at the input.
  logic       accept;
  logic       is_tick;
  logic       is_read;
  logic       is_write;
  logic [3:0] word_sel;
  logic [1:0] lane_sel;
  logic [1:0] timer_sel;
  logic       timer_hit;

  // Architectural registers.
  logic [CTRL_W-1:0]   control_r, control_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [31:0]         mask_r, mask_nxt;

  // Events travel two ticks before they become visible in the status
  // register: stage one holds the events of the last tick, stage zero the
  // ones that land on the next tick. Interrupt pulses follow through three
  // more stages into the held interrupt line.
  logic [STATUS_W-1:0]   pst1_r, pst1_nxt;
  logic [STATUS_W-1:0]   pst0_r, pst0_nxt;
  logic [MAX_TIMERS-1:0] pirq2_r, pirq2_nxt;
  logic [MAX_TIMERS-1:0] pirq1_r, pirq1_nxt;
  logic [MAX_TIMERS-1:0] pirq0_r, pirq0_nxt;
  logic [MAX_TIMERS-1:0] irq_r, irq_nxt;

  // Output register.
  logic       out_valid_r;
  logic [7:0] out_read_data_r;
  logic [2:0] out_timer_irq_r;

  // Channel interface.
  chan_ctl_t   chan_ctl [TIMER_COUNT];
  logic [2:0]  chan_ev  [TIMER_COUNT];
  logic [31:0] chan_rd  [TIMER_COUNT];

  logic [STATUS_W-1:0] tick_ev;
  logic [STATUS_W-1:0] clr_bits;
  logic [31:0]         clr_full;
  logic [31:0]         timer_word;
  logic [31:0]         rd_word;
  logic [7:0]          rd_byte;
  logic [31:0]         ctrl_merged;
  logic [31:0]         mask_merged;

  // The output register decouples the two sides: a new item is taken while
  // the register is empty or the waiting result leaves in this same cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign is_tick  = accept && (kind_t'(in_kind) == KIND_TICK);
  assign is_read  = accept && (kind_t'(in_kind) == KIND_READ);
  assign is_write = accept && (kind_t'(in_kind) == KIND_WRITE);

  assign word_sel  = in_address[5:2];
  assign lane_sel  = in_address[1:0];
  assign timer_sel = in_address[5:4];
  // The upper quarter of the map is the shared registers; timer banks that
  // are not built read as zero and drop writes.
  assign timer_hit = ({1'b0, timer_sel} < 3'(TIMER_COUNT));

  // One channel per timer; a timer moves on a tick only when enabled, and
  // with the slow clock selected only when the slow strobe is present.
  for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_chan
    always_comb begin
      chan_ctl[i].tick    = is_tick && control_r[3*i] &&
                            (!control_r[3*i+1] || in_slow_tick);
      chan_ctl[i].up      = control_r[9+i];
      chan_ctl[i].wr      = is_write && timer_hit && (timer_sel == 2'(i));
      chan_ctl[i].sub     = in_address[3:2];
      chan_ctl[i].lane    = lane_sel;
      chan_ctl[i].wr_byte = in_write_data;
    end

    gpt_channel u_chan (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_i    (chan_ctl[i]),
      .ev_o     (chan_ev[i]),
      .rd_word_o(chan_rd[i])
    );
  end

  // Collect the tick events into the status layout. The overflow bit is
  // only raised when that timer's overflow status enable is set.
  always_comb begin
    tick_ev    = '0;
    timer_word = '0;
    for (int i = 0; i < TIMER_COUNT; i++) begin
      tick_ev[3*i +: 3] = {chan_ev[i][2] && control_r[3*i+2], chan_ev[i][1:0]};
      if (timer_sel == 2'(i)) begin
        timer_word = chan_rd[i];
      end
    end
  end

  // Read path.
  always_comb begin
    if (timer_hit) begin
      rd_word = timer_word;
    end else begin
      case (word_sel)
        REG_CONTROL:  rd_word = 32'(control_r);
        REG_STATUS:   rd_word = 32'(status_r);
        REG_MASK:     rd_word = mask_r;
        REG_REVISION: rd_word = REVISION_WORD;
        default:      rd_word = '0;
      endcase
    end
  end

  assign rd_byte = is_read ? rd_word[{lane_sel, 3'b000} +: 8] : 8'h00;

  assign ctrl_merged = merge_byte(32'(control_r), lane_sel, in_write_data);
  assign mask_merged = merge_byte(mask_r, lane_sel, in_write_data);
  assign clr_full    = 32'(in_write_data) << {lane_sel, 3'b000};
  assign clr_bits    = clr_full[STATUS_W-1:0];

  // Next state of the shared registers and the event pipelines.
  always_comb begin
    control_nxt = control_r;
    status_nxt  = status_r;
    mask_nxt    = mask_r;
    pst1_nxt    = pst1_r;
    pst0_nxt    = pst0_r;
    pirq2_nxt   = pirq2_r;
    pirq1_nxt   = pirq1_r;
    pirq0_nxt   = pirq0_r;
    irq_nxt     = irq_r;

    if (is_tick) begin
      status_nxt = status_r | pst0_r;
      irq_nxt    = pirq0_r;
      pirq0_nxt  = pirq1_r;
      pirq1_nxt  = pirq2_r;
      // A timer's interrupt starts when any of its events leaves stage one.
      for (int i = 0; i < MAX_TIMERS; i++) begin
        pirq2_nxt[i] = |pst1_r[3*i +: 3];
      end
      pst0_nxt = pst1_r;
      pst1_nxt = tick_ev;
    end

    if (is_write && !timer_hit) begin
      case (word_sel)
        REG_CONTROL: control_nxt = ctrl_merged[CTRL_W-1:0];
        REG_STATUS: begin
          // Write one to clear, which also cancels events about to land.
          status_nxt = status_r & ~clr_bits;
          pst0_nxt   = pst0_r & ~clr_bits;
        end
        REG_MASK:    mask_nxt = mask_merged;
        default:     control_nxt = control_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r <= '0;
      status_r  <= '0;
      mask_r    <= '0;
      pst1_r    <= '0;
      pst0_r    <= '0;
      pirq2_r   <= '0;
      pirq1_r   <= '0;
      pirq0_r   <= '0;
      irq_r     <= '0;
    end else begin
      control_r <= control_nxt;
      status_r  <= status_nxt;
      mask_r    <= mask_nxt;
      pst1_r    <= pst1_nxt;
      pst0_r    <= pst0_nxt;
      pirq2_r   <= pirq2_nxt;
      pirq1_r   <= pirq1_nxt;
      pirq0_r   <= pirq0_nxt;
      irq_r     <= irq_nxt;
    end
  end

  // Result register: loads on every accepted item, empties when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_data_r <= rd_byte;
      out_timer_irq_r <= irq_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_timer_irq = out_timer_irq_r;

endmodule

FILE: hw/rtl/gpt_checker.sv
// ----------------------------------------------------------------------------
// General purpose timer checker
// Port-level assertions on the timer block, attached by a bind statement.
// ----------------------------------------------------------------------------
module gpt_checker import gpt_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_kind,
  input logic [5:0] in_address,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic [2:0] out_timer_irq
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) &&
                                $stable(out_timer_irq))
    else $error("result word changed while stalled");

  // The block never refuses input while its result register is empty.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Anything but a read returns a zero data byte.
  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_kind != KIND_READ) |=> out_valid && (out_read_data == 8'h00))
    else $error("non-read word carries read data");

  // The two low bytes of the revision word read back their fixed value.
  a_revision_lo: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_kind == KIND_READ) && (in_address == 6'h3C)
    |=> out_read_data == REVISION_WORD[7:0])
    else $error("revision byte 0 wrong");

  a_revision_b1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_kind == KIND_READ) && (in_address == 6'h3D)
    |=> out_read_data == REVISION_WORD[15:8])
    else $error("revision byte 1 wrong");

endmodule

bind general_purpose_timer_block_unit gpt_checker u_gpt_checker (.*);

FILE: tb/general_purpose_timer_block_unit_test.sv
// ----------------------------------------------------------------------------
// General purpose timer block testbench
// Feeds clock ticks, register reads and register writes into the three
// channel match timer. The source idles in random bursts and the sink stalls
// on its own pattern. Every result word is compared against a predictor that
// keeps its own copy of the counters, the status and the delay pipelines.
// ----------------------------------------------------------------------------
module general_purpose_timer_block_unit_test import gpt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // The kind code that the block has to ignore.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Byte addresses of the shared registers.
  localparam logic [5:0] ADDR_CONTROL0  = {REG_CONTROL, 2'd0};
  localparam logic [5:0] ADDR_CONTROL1  = {REG_CONTROL, 2'd1};
  localparam logic [5:0] ADDR_STATUS0   = {REG_STATUS, 2'd0};
  localparam logic [5:0] ADDR_STATUS1   = {REG_STATUS, 2'd1};
  localparam logic [5:0] ADDR_MASK0     = {REG_MASK, 2'd0};
  localparam logic [5:0] ADDR_REVISION0 = {REG_REVISION, 2'd0};
  localparam logic [5:0] ADDR_REVISION3 = {REG_REVISION, 2'd3};

  localparam logic [31:0] COUNT_MASK = 32'hFFFF_FFFF >> (32 - COUNT_WIDTH);

  // Number of random words offered after the directed table.
  localparam int RANDOM_ITEMS = 1350;
  localparam int DIRECTED_ROWS = 27;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] address;
    logic [7:0] write_data;
    logic       slow_tick;
  } bus_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] timer_irq;
  } result_word_t;

  // One row of the directed table. When known is set, the result typed in
  // the row is the expectation; otherwise the predictor supplies it.
  typedef struct packed {
    bus_item_t    item;
    logic         known;
    result_word_t result;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_kind;
  logic [5:0] in_address;
  logic [7:0] in_write_data;
  logic       in_slow_tick;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_read_data;
  logic [2:0] out_timer_irq;

  general_purpose_timer_block_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_address   (in_address),
    .in_write_data(in_write_data),
    .in_slow_tick (in_slow_tick),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_read_data(out_read_data),
    .out_timer_irq(out_timer_irq)
  );

  // 10 ns clock. It starts low so the first rising edge comes at 5 ns.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Predicted state of the timer block.
  // --------------------------------------------------------------------------
  logic [31:0]           tm_count  [MAX_TIMERS];
  logic [31:0]           tm_reload [MAX_TIMERS];
  logic [31:0]           tm_match  [2*MAX_TIMERS];
  logic [CTRL_W-1:0]     tm_control;
  logic [STATUS_W-1:0]   tm_status;
  logic [31:0]           tm_mask;
  // Status events on their way to the status register. The low nine bits
  // become visible on the next tick, the next nine bits one tick later.
  logic [3*STATUS_W-1:0] tm_status_pipe;
  // Interrupt pulses in flight, three bits per stage, lowest stage first.
  logic [STATUS_W-1:0]   tm_irq_pipe;
  logic [MAX_TIMERS-1:0] tm_irq_line;

  result_word_t expected_words[$];
  int           errors;
  int           items_sent;
  int           burst_left;
  bit           random_phase;

  // Full 32-bit view of one register word as the bus sees it.
  function automatic logic [31:0] register_word(input logic [3:0] word);
    logic [31:0] value;
    int          t;
    t = int'(word[3:2]);
    value = '0;
    if (word < REG_CONTROL) begin
      // Timers that are not built read back as zero.
      if (t < TIMER_COUNT) begin
        case (word[1:0])
          SUB_COUNT:  value = tm_count[t];
          SUB_RELOAD: value = tm_reload[t];
          SUB_MATCH0: value = tm_match[2*t];
          default:    value = tm_match[2*t+1];
        endcase
      end
    end else if (word == REG_CONTROL) begin
      value = 32'(tm_control);
    end else if (word == REG_STATUS) begin
      value = 32'(tm_status);
    end else if (word == REG_MASK) begin
      value = tm_mask;
    end else begin
      value = REVISION_WORD;
    end
    return value;
  endfunction

  function automatic void write_register_byte(input logic [5:0] address,
                                              input logic [7:0] data);
    logic [3:0]            word;
    logic [31:0]           lane;
    logic [31:0]           bits;
    logic [31:0]           merged;
    logic [3*STATUS_W-1:0] clr;
    int                    t;
    word   = address[5:2];
    t      = int'(word[3:2]);
    lane   = 32'h0000_00FF << {address[1:0], 3'b000};
    bits   = 32'(data) << {address[1:0], 3'b000};
    merged = (register_word(word) & ~lane) | bits;
    clr    = '0;
    clr[STATUS_W-1:0] = bits[STATUS_W-1:0];
    case (word)
      REG_STATUS: begin
        // Write one to clear. The clear also kills events that would have
        // reached the status register on the very next tick.
        tm_status      &= ~clr[STATUS_W-1:0];
        tm_status_pipe &= ~clr;
      end
      REG_REVISION: ;
      REG_CONTROL: tm_control = merged[CTRL_W-1:0];
      REG_MASK:    tm_mask = merged;
      default: begin
        if (t < TIMER_COUNT) begin
          merged &= COUNT_MASK;
          case (word[1:0])
            SUB_COUNT:  tm_count[t] = merged;
            SUB_RELOAD: tm_reload[t] = merged;
            SUB_MATCH0: tm_match[2*t] = merged;
            default:    tm_match[2*t+1] = merged;
          endcase
        end
      end
    endcase
  endfunction

  // One CPU clock tick: the delay pipelines move first, then every timer
  // that is enabled and clocked compares, and then reloads or steps.
  function automatic void advance_timers(input logic slow);
    logic [STATUS_W-1:0] stage1;
    logic [2:0]          mode;
    logic [2:0]          ev;
    logic                up;
    logic [31:0]         cnt;
    logic [31:0]         term;
    tm_status  |= tm_status_pipe[STATUS_W-1:0];
    tm_irq_line = tm_irq_pipe[MAX_TIMERS-1:0];
    tm_irq_pipe = tm_irq_pipe >> MAX_TIMERS;
    stage1      = tm_status_pipe[2*STATUS_W-1 -: STATUS_W];
    for (int i = 0; i < MAX_TIMERS; i++) begin
      if (stage1[3*i +: 3] != 3'b000) begin
        tm_irq_pipe[2*MAX_TIMERS + i] = 1'b1;
      end
    end
    tm_status_pipe = tm_status_pipe >> STATUS_W;
    for (int i = 0; i < TIMER_COUNT; i++) begin
      mode = tm_control[3*i +: 3];
      up   = tm_control[3*MAX_TIMERS + i];
      cnt  = tm_count[i] & COUNT_MASK;
      term = up ? COUNT_MASK : 32'h0;
      ev   = 3'b000;
      if (mode[0] && (!mode[1] || slow)) begin
        if (cnt == tm_match[2*i]) begin
          ev[0] = 1'b1;
        end
        if (cnt == tm_match[2*i+1]) begin
          ev[1] = 1'b1;
        end
        if (cnt == term) begin
          ev[2] = mode[2];
          cnt   = tm_reload[i];
        end else begin
          cnt = up ? cnt + 32'd1 : cnt - 32'd1;
        end
        tm_count[i] = cnt & COUNT_MASK;
        tm_status_pipe[STATUS_W + 3*i +: 3] |= ev;
      end
    end
  endfunction

  // Result word that the block owes for one accepted input word.
  function automatic result_word_t predict_result(input bus_item_t it);
    logic [31:0]  word_value;
    result_word_t res;
    res.read_data = '0;
    case (it.kind)
      KIND_TICK:  advance_timers(it.slow_tick);
      KIND_READ: begin
        word_value    = register_word(it.address[5:2]) >> {it.address[1:0], 3'b000};
        res.read_data = word_value[7:0];
      end
      KIND_WRITE: write_register_byte(it.address, it.write_data);
      default: ;
    endcase
    // Reads, writes and the unused kind repeat the level of the last tick.
    res.timer_irq = tm_irq_line;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table. Rows with a typed result hold values that follow from
  // reset, the revision constant or the fact that writes return zero.
  // --------------------------------------------------------------------------
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // Everything reads zero after reset.
    '{'{KIND_READ,  {2'd0, SUB_COUNT, 2'd0}, 8'h00, 1'b0}, 1'b1, '{8'h00, 3'd0}},
    '{'{KIND_READ,  ADDR_STATUS0,   8'h00, 1'b0}, 1'b1, '{8'h00, 3'd0}},
    // Revision word, lowest and highest byte address.
    '{'{KIND_READ,  ADDR_REVISION0, 8'h00, 1'b0}, 1'b1, '{8'h01, 3'd0}},
    '{'{KIND_READ,  ADDR_REVISION3, 8'h00, 1'b1}, 1'b1, '{8'h00, 3'd0}},
    // The revision word is read only.
    '{'{KIND_WRITE, ADDR_REVISION0, 8'hFF, 1'b0}, 1'b1, '{8'h00, 3'd0}},
    '{'{KIND_READ,  ADDR_REVISION0, 8'h00, 1'b0}, 1'b1, '{8'h01, 3'd0}},
    // The unused kind does nothing and returns zero.
    '{'{KIND_UNUSED, ADDR_REVISION3, 8'hFF, 1'b1}, 1'b1, '{8'h00, 3'd0}},
    // A tick with every timer disabled.
    '{'{KIND_TICK,  6'd0,           8'h00, 1'b1}, 1'b1, '{8'h00, 3'd0}},
    // The mask register is plain storage and never gates the interrupts.
    '{'{KIND_WRITE, ADDR_MASK0,     8'hFF, 1'b0}, 1'b1, '{8'h00, 3'd0}},
    '{'{KIND_READ,  ADDR_MASK0,     8'h00, 1'b0}, 1'b0, '{8'h00, 3'd0}},
    // Timer 0 counts down from 2 and hits match 0 at 1.
    '{'{KIND_WRITE, {2'd0, SUB_COUNT, 2'd0},  8'h02, 1'b0}, 1'b0, '{8'h00, 3'd0}},
    '{'{KIND_WRITE, {2'd0, SUB_MATCH0, 2'd0}, 8'h01, 1'b0}, 1'b0, '{8'h00, 3'd0}},
    // Timer 1 counts up from one below all ones on the slow strobe.
    '{'{KIND_WRITE, {2'd1, SUB_COUNT, 2'd3},  8'hFF, 1'b0}, 1'b0, '{8'h00, 3'd0}},
    '{'{KIND_WRITE, {2'd1, SUB_COUNT, 2'd2},  8'hFF, 1'b0}, 1'b0, '{8'h00, 3'd0}},
    '{'{KIND_WRITE, {2'd1, SUB_COUNT, 2'd1},  8'hFF, 1'b0}, 1'b0, '{8'h00, 3'd0}},
    '{'{KIND_WRITE, {2'd1, SUB_COUNT, 2'd0},  8'hFE, 1'b0}, 1'b0, '{8'h00, 3'd0}},
    // Enable timer 0 with overflow status, timer 1 on the slow clock, up.
    '{'{KIND_WRITE, ADDR_CONTROL0,  8'h1D, 1'b0}, 1'b0, '{8'h00, 3'd0}},
    '{'{KIND_WRITE, ADDR_CONTROL1,  8'h04, 1'b0}, 1'b0, '{8'h00, 3'd0}},
    // Ticks through both terminal counts and the delayed interrupts.
    '{'{KIND_TICK,  6'd0,           8'h00, 1'b0}, 1'b0, '{8'h00, 3'd0}},
    '{'{KIND_TICK,  6'd0,           8'h00, 1'b1}, 1'b0, '{8'h00, 3'd0}},
    '{'{KIND_TICK,  6'd0,           8'h00, 1'b1}, 1'b0, '{8'h00, 3'd0}},
    '{'{KIND_TICK,  6'd0,           8'h00, 1'b0}, 1'b0, '{8'h00, 3'd0}},
    '{'{KIND_TICK,  6'd0,           8'h00, 1'b1}, 1'b0, '{8'h00, 3'd0}},
    '{'{KIND_TICK,  6'd0,           8'h00, 1'b0}, 1'b0, '{8'h00, 3'd0}},
    // Status, then write one to clear all of it.
    '{'{KIND_READ,  ADDR_STATUS0,   8'h00, 1'b0}, 1'b0, '{8'h00, 3'd0}},
    '{'{KIND_WRITE, ADDR_STATUS0,   8'hFF, 1'b0}, 1'b0, '{8'h00, 3'd0}},
    '{'{KIND_READ,  ADDR_STATUS0,   8'h00, 1'b0}, 1'b0, '{8'h00, 3'd0}}
  };

  // --------------------------------------------------------------------------
  // Source side. Words go out in bursts of random length; between bursts
  // valid may drop for a random gap. Once valid is up it stays up, with the
  // payload held, until the word is taken.
  // --------------------------------------------------------------------------
  task automatic send_item(input bus_item_t it, input logic known,
                           input result_word_t typed);
    int           gap;
    result_word_t want;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_kind       <= it.kind;
    in_address    <= it.address;
    in_write_data <= it.write_data;
    in_slow_tick  <= it.slow_tick;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // The word was taken at this edge, so the predictor steps now.
    want = predict_result(it);
    if (known) begin
      want = typed;
    end
    expected_words.push_back(want);
    if (it.kind != KIND_UNUSED) begin
      items_sent++;
    end
  endtask

  task automatic send_op(input logic [1:0] kind, input logic [5:0] address,
                         input logic [7:0] data, input logic slow);
    bus_item_t it;
    it.kind       = kind;
    it.address    = address;
    it.write_data = data;
    it.slow_tick  = slow;
    send_item(it, 1'b0, '0);
  endtask

  task automatic write_timer_word(input int t, input logic [1:0] sub,
                                  input logic [31:0] value);
    logic [1:0] bank;
    bank = 2'(t);
    for (int b = 0; b < 4; b++) begin
      send_op(KIND_WRITE, {bank, sub, 2'(b)}, value[8*b +: 8], 1'($urandom));
    end
  endtask

  // A well formed sequence: program one timer close to a match and to its
  // terminal count, enable it, then tick it with reads and status clears
  // mixed in so that status and interrupt timing are exercised.
  task automatic run_timer_scenario();
    int          t;
    int          ticks;
    int          pick;
    logic        up;
    logic [31:0] start;
    logic [31:0] reload;
    logic [31:0] m0;
    logic [31:0] m1;
    logic [CTRL_W-1:0] ctl;
    logic [1:0]  bank;
    t    = $urandom_range(0, MAX_TIMERS - 1);
    bank = 2'(t);
    up   = 1'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      start = $urandom;
    end else begin
      start = up ? COUNT_MASK - $urandom_range(0, 8) : $urandom_range(0, 8);
    end
    if ($urandom_range(0, 3) == 0) begin
      reload = $urandom;
    end else begin
      reload = up ? COUNT_MASK - $urandom_range(0, 12) : $urandom_range(0, 12);
    end
    m0 = up ? start + $urandom_range(0, 6) : start - $urandom_range(0, 6);
    if ($urandom_range(0, 4) == 0) begin
      m1 = $urandom;
    end else begin
      m1 = up ? reload + $urandom_range(0, 4) : reload - $urandom_range(0, 4);
    end
    write_timer_word(t, SUB_RELOAD, reload);
    write_timer_word(t, SUB_MATCH0, m0);
    write_timer_word(t, SUB_MATCH1, m1);
    write_timer_word(t, SUB_COUNT, start);

    // Start from the current control value; now and then scramble the
    // other timers too so that several run at once.
    ctl = tm_control;
    if ($urandom_range(0, 2) == 0) begin
      ctl = CTRL_W'($urandom);
    end
    ctl[3*t]              = ($urandom_range(0, 9) != 0);
    ctl[3*t + 1]          = ($urandom_range(0, 3) == 0);
    ctl[3*t + 2]          = 1'($urandom);
    ctl[3*MAX_TIMERS + t] = up;
    send_op(KIND_WRITE, ADDR_CONTROL0, ctl[7:0], 1'($urandom));
    // The upper nibble of the second byte is random and must be dropped.
    send_op(KIND_WRITE, ADDR_CONTROL1, {4'($urandom), ctl[11:8]}, 1'($urandom));

    ticks = $urandom_range(6, 40);
    for (int n = 0; n < ticks; n++) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        send_op(KIND_TICK, 6'($urandom), 8'($urandom), 1'($urandom));
      end else if (pick < 16) begin
        send_op(KIND_READ, {REG_STATUS, 2'($urandom)}, 8'($urandom), 1'($urandom));
      end else if (pick < 18) begin
        send_op(KIND_READ, {bank, 2'($urandom), 2'($urandom)}, 8'($urandom),
                1'($urandom));
      end else begin
        send_op(KIND_WRITE, {REG_STATUS, 2'($urandom_range(0, 1))}, 8'($urandom),
                1'($urandom));
      end
    end
    send_op(KIND_READ, ADDR_STATUS0, 8'h00, 1'b0);
    send_op(KIND_READ, ADDR_STATUS1, 8'h00, 1'b0);
  endtask

  // Noise: a few words with every field fully random, the unused kind too.
  task automatic run_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      send_op(2'($urandom), 6'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Sink side. The stall pattern changes every segment: always ready, coin
  // flip, a periodic pattern, or mostly stalled. Once, early in the random
  // part, it holds off for a long stretch while the source keeps offering,
  // so the output register fills and the input is backed up.
  // --------------------------------------------------------------------------
  initial begin
    int seg_left;
    int mode;
    int period;
    int phase_cnt;
    int random_cycles;
    bit held;
    seg_left      = 0;
    mode          = 0;
    period        = 2;
    phase_cnt     = 0;
    random_cycles = 0;
    held          = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(10, 120);
        period   = $urandom_range(2, 7);
      end
      seg_left--;
      phase_cnt++;
      if (random_phase) begin
        random_cycles++;
      end
      if (!held && random_cycles == 300) begin
        out_ready <= 1'b0;
        repeat (150) @(posedge clk);
        held = 1'b1;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom);
          2:       out_ready <= ((phase_cnt % period) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker. Every word taken from the output is matched, field by
  // field, against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: read_data %02h timer_irq %0h",
               out_read_data, out_timer_irq);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (out_read_data !== want.read_data) begin
          $error("read_data: expected %02h, actual %02h", want.read_data, out_read_data);
          errors++;
        end
        if (out_timer_irq !== want.timer_irq) begin
          $error("timer_irq: expected %0h, actual %0h", want.timer_irq, out_timer_irq);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed table, random part, drain.
  // --------------------------------------------------------------------------
  initial begin
    int drain;
    errors       = 0;
    items_sent   = 0;
    burst_left   = 0;
    random_phase = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_kind       <= KIND_TICK;
    in_address    <= '0;
    in_write_data <= '0;
    in_slow_tick  <= 1'b0;

    // The predictor starts from the reset state of the block.
    for (int i = 0; i < MAX_TIMERS; i++) begin
      tm_count[i]  = '0;
      tm_reload[i] = '0;
    end
    for (int i = 0; i < 2*MAX_TIMERS; i++) begin
      tm_match[i] = '0;
    end
    tm_control     = '0;
    tm_status      = '0;
    tm_mask        = '0;
    tm_status_pipe = '0;
    tm_irq_pipe    = '0;
    tm_irq_line    = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].item, directed_rows[r].known, directed_rows[r].result);
    end

    random_phase = 1'b1;
    while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        run_noise();
      end else begin
        run_timer_scenario();
      end
    end
    in_valid <= 1'b0;

    // Wait for the outstanding words, then a few more cycles so that any
    // stray extra word would still be caught.
    drain = 0;
    while (expected_words.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d expected result words never arrived", expected_words.size());
      errors++;
    end
    if (errors == 0) begin
      $display("general_purpose_timer_block_unit_test: clean");
    end else begin
      $display("general_purpose_timer_block_unit_test: errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("general_purpose_timer_block_unit_test: errors");
    $finish;
  end

endmodule
